// ===== design/mlqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_pkg
// Shared types and constants for the multilevel queue scheduler.
// ----------------------------------------------------------------------------
package mlqs_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 256;
    localparam int DEFAULT_TIME_BITS   = 32;

    localparam int PID_W   = 16;
    localparam int BURST_W = 16;
    localparam int OTIME_W = 32;
    localparam int SUM_W   = 48;

    localparam logic [BURST_W-1:0] TIME_SLICE_RESET = 16'd4;

    // register index, taken from paddr[2]
    localparam logic REG_TIME_SLICE = 1'b0;

    localparam logic REQ_ENQUEUE  = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    localparam logic CLASS_RR   = 1'b0;
    localparam logic CLASS_FCFS = 1'b1;

    typedef enum logic [1:0] {
        OP_ENQ_RR,
        OP_ENQ_FCFS,
        OP_DISPATCH
    } op_t;

    typedef struct packed {
        logic               req_type;
        logic [BURST_W-1:0] burst;
        logic               queue_class;
    } req_in_t;

    typedef struct packed {
        op_t                op;
        logic [BURST_W-1:0] burst;
    } sched_req_t;

    typedef struct packed {
        logic               slice_valid;
        logic [PID_W-1:0]   slice_pid;
        logic [OTIME_W-1:0] start_time;
        logic [OTIME_W-1:0] finish_time;
        logic               completed;
        logic               all_done;
        logic               rejected;
        logic [SUM_W-1:0]   wait_sum;
        logic [SUM_W-1:0]   finish_sum;
        logic [PID_W-1:0]   process_count;
    } result_t;

endpackage

// ===== design/mlqs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_front
// Request intake: classifies each request and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module mlqs_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mlqs_pkg::req_in_t    s_data,
    output logic                 req_valid,
    output mlqs_pkg::sched_req_t req,
    input  logic                 req_pop
);
    import mlqs_pkg::*;

    sched_req_t  entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    sched_req_t  cls;

    always_comb begin
        cls.burst = s_data.burst;
        if (s_data.req_type == REQ_DISPATCH) begin
            cls.op = OP_DISPATCH;
        end else if (s_data.queue_class == CLASS_FCFS) begin
            cls.op = OP_ENQ_FCFS;
        end else begin
            cls.op = OP_ENQ_RR;
        end
    end

    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign req_valid = (count_reg != 2'd0);
    assign req       = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (req_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, req_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/mlqs_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_engine
// Scheduling back end: queue memories, time keeping, sums and result register.
// ----------------------------------------------------------------------------
module mlqs_engine #(
    parameter int QUEUE_DEPTH = mlqs_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int TIME_BITS   = mlqs_pkg::DEFAULT_TIME_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          time_slice,
    input  logic                 req_valid,
    input  mlqs_pkg::sched_req_t req,
    output logic                 req_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mlqs_pkg::result_t    m_data
);
    import mlqs_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0]        FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0]        LAST_IDX   = AW'(QUEUE_DEPTH - 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX   = '1;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [BURST_W-1:0] remaining;
        logic [BURST_W-1:0] original;
    } rr_entry_t;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [BURST_W-1:0] length;
    } fc_entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_SUM
    } state_t;

    rr_entry_t rr_mem [QUEUE_DEPTH];
    fc_entry_t fc_mem [QUEUE_DEPTH];
    rr_entry_t rr_rd_reg;
    fc_entry_t fc_rd_reg;

    state_t               state_reg;
    logic                 m_valid_reg;
    result_t              m_data_reg;
    logic [AW-1:0]        rr_head_reg, rr_tail_reg, fc_head_reg, fc_tail_reg;
    logic [CW-1:0]        rr_count_reg, fc_count_reg;
    logic [TIME_BITS-1:0] time_reg, start_reg;
    logic [SUM_W-1:0]     wait_total_reg, finish_total_reg, wait_reg;
    logic [PID_W-1:0]     pid_reg, pid_hold_reg;
    logic [BURST_W-1:0]   orig_reg;
    logic                 src_fcfs_reg;

    logic                 out_free;
    logic                 res_load;
    logic [BURST_W-1:0]   quantum;
    logic                 enq_ok;
    logic [PID_W-1:0]     pid_next;
    logic [PID_W-1:0]     x_pid;
    logic [BURST_W-1:0]   x_orig;
    logic [BURST_W-1:0]   x_slice;
    logic                 x_done;
    logic [TIME_BITS:0]   tsum;
    logic [TIME_BITS-1:0] time_next;
    logic [TIME_BITS-1:0] wdiff;
    logic [SUM_W-1:0]     wait_total_next;
    logic                 rr_we, fc_we;
    rr_entry_t            rr_wdata;
    fc_entry_t            fc_wdata;
    result_t              res_idle, res_exec, res_sum;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign req_pop  = (state_reg == S_IDLE) && req_valid && out_free;
    assign quantum  = (time_slice == '0) ? 16'd1 : time_slice;
    assign pid_next = pid_reg + 1'b1;

    always_comb begin
        enq_ok = (pid_reg != '1);
        if (req.op == OP_ENQ_FCFS) begin
            enq_ok = enq_ok && (fc_count_reg != FULL_COUNT);
        end else begin
            enq_ok = enq_ok && (rr_count_reg != FULL_COUNT);
        end
    end

    // slice of the entry read from the head of the selected queue
    always_comb begin
        if (src_fcfs_reg) begin
            x_pid   = fc_rd_reg.pid;
            x_orig  = fc_rd_reg.length;
            x_slice = fc_rd_reg.length;
            x_done  = 1'b1;
        end else begin
            x_pid  = rr_rd_reg.pid;
            x_orig = rr_rd_reg.original;
            x_done = (rr_rd_reg.remaining <= quantum);
            x_slice = x_done ? rr_rd_reg.remaining : quantum;
        end
    end

    // a result is registered on this edge
    assign res_load = (req_pop && !((req.op == OP_DISPATCH)
                                    && ((rr_count_reg != '0) || (fc_count_reg != '0))))
                   || ((state_reg == S_EXEC) && !x_done)
                   || (state_reg == S_SUM);

    assign tsum      = {1'b0, time_reg} + (TIME_BITS + 1)'(x_slice);
    assign time_next = tsum[TIME_BITS] ? TIME_MAX : tsum[TIME_BITS-1:0];
    assign wdiff     = time_reg - TIME_BITS'(orig_reg);
    assign wait_total_next = sat_add(wait_total_reg, wait_reg);

    assign rr_we = (req_pop && (req.op == OP_ENQ_RR) && enq_ok)
                || ((state_reg == S_EXEC) && !src_fcfs_reg && !x_done);
    assign fc_we = req_pop && (req.op == OP_ENQ_FCFS) && enq_ok;

    always_comb begin
        if (state_reg == S_EXEC) begin
            rr_wdata.pid       = rr_rd_reg.pid;
            rr_wdata.remaining = rr_rd_reg.remaining - quantum;
            rr_wdata.original  = rr_rd_reg.original;
        end else begin
            rr_wdata.pid       = pid_next;
            rr_wdata.remaining = req.burst;
            rr_wdata.original  = req.burst;
        end
        fc_wdata.pid    = pid_next;
        fc_wdata.length = req.burst;
    end

    always_comb begin
        res_idle = '0;
        res_idle.wait_sum      = wait_total_reg;
        res_idle.finish_sum    = finish_total_reg;
        res_idle.process_count = pid_reg;
        if (req.op == OP_DISPATCH) begin
            res_idle.all_done = 1'b1;
        end else begin
            res_idle.rejected = !enq_ok;
            res_idle.all_done = !enq_ok && (rr_count_reg == '0) && (fc_count_reg == '0);
            if (enq_ok) begin
                res_idle.process_count = pid_next;
            end
        end

        res_exec = '0;
        res_exec.slice_valid   = 1'b1;
        res_exec.slice_pid     = x_pid;
        res_exec.start_time    = OTIME_W'(time_reg);
        res_exec.finish_time   = OTIME_W'(time_next);
        res_exec.wait_sum      = wait_total_reg;
        res_exec.finish_sum    = finish_total_reg;
        res_exec.process_count = pid_reg;

        res_sum.slice_valid   = 1'b1;
        res_sum.slice_pid     = pid_hold_reg;
        res_sum.start_time    = OTIME_W'(start_reg);
        res_sum.finish_time   = OTIME_W'(time_reg);
        res_sum.completed     = 1'b1;
        res_sum.all_done      = (rr_count_reg == '0) && (fc_count_reg == '0);
        res_sum.rejected      = 1'b0;
        res_sum.wait_sum      = wait_total_next;
        res_sum.finish_sum    = finish_total_reg;
        res_sum.process_count = pid_reg;
    end

    always_ff @(posedge aclk) begin
        if (rr_we) begin
            rr_mem[rr_tail_reg] <= rr_wdata;
        end
        rr_rd_reg <= rr_mem[rr_head_reg];
    end

    always_ff @(posedge aclk) begin
        if (fc_we) begin
            fc_mem[fc_tail_reg] <= fc_wdata;
        end
        fc_rd_reg <= fc_mem[fc_head_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            m_valid_reg      <= 1'b0;
            rr_head_reg      <= '0;
            rr_tail_reg      <= '0;
            rr_count_reg     <= '0;
            fc_head_reg      <= '0;
            fc_tail_reg      <= '0;
            fc_count_reg     <= '0;
            time_reg         <= '0;
            wait_total_reg   <= '0;
            finish_total_reg <= '0;
            pid_reg          <= '0;
            src_fcfs_reg     <= 1'b0;
        end else begin
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (req_pop) begin
                        unique case (req.op)
                            OP_ENQ_RR, OP_ENQ_FCFS: begin
                                m_data_reg <= res_idle;
                                if (enq_ok) begin
                                    pid_reg <= pid_next;
                                    if (req.op == OP_ENQ_FCFS) begin
                                        fc_tail_reg  <= wrap_inc(fc_tail_reg);
                                        fc_count_reg <= fc_count_reg + 1'b1;
                                    end else begin
                                        rr_tail_reg  <= wrap_inc(rr_tail_reg);
                                        rr_count_reg <= rr_count_reg + 1'b1;
                                    end
                                end
                            end
                            OP_DISPATCH: begin
                                if (rr_count_reg != '0) begin
                                    rr_head_reg  <= wrap_inc(rr_head_reg);
                                    rr_count_reg <= rr_count_reg - 1'b1;
                                    src_fcfs_reg <= 1'b0;
                                    state_reg    <= S_EXEC;
                                end else if (fc_count_reg != '0) begin
                                    fc_head_reg  <= wrap_inc(fc_head_reg);
                                    fc_count_reg <= fc_count_reg - 1'b1;
                                    src_fcfs_reg <= 1'b1;
                                    state_reg    <= S_EXEC;
                                end else begin
                                    m_data_reg <= res_idle;
                                end
                            end
                            default: begin
                                m_data_reg <= res_idle;
                            end
                        endcase
                    end
                end
                S_EXEC: begin
                    start_reg    <= time_reg;
                    time_reg     <= time_next;
                    pid_hold_reg <= x_pid;
                    orig_reg     <= x_orig;
                    if (x_done) begin
                        state_reg <= S_WAIT;
                    end else begin
                        rr_tail_reg  <= wrap_inc(rr_tail_reg);
                        rr_count_reg <= rr_count_reg + 1'b1;
                        m_data_reg   <= res_exec;
                        state_reg    <= S_IDLE;
                    end
                end
                S_WAIT: begin
                    wait_reg <= (time_reg >= TIME_BITS'(orig_reg)) ? SUM_W'(wdiff) : '0;
                    finish_total_reg <= sat_add(finish_total_reg, SUM_W'(time_reg));
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    wait_total_reg <= wait_total_next;
                    m_data_reg     <= res_sum;
                    state_reg      <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/multilevel_queue_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler
// Two-level scheduler: round-robin queue served before a FCFS queue.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. Enqueues and a dispatch that finds
// both queues empty stay in the idle state; a dispatch goes through EXEC
// when the round-robin head is requeued and through EXEC, WAIT and SUM on
// completion (head memory read, time update, waiting time, then the
// saturating sums). A two-entry request queue in front takes requests while
// the back end is busy or a result waits; s_ready falls once it holds two.
// time_slice sits at byte address 0 and resets to 4; a slice of 0 acts as 1.
// The queue stores hold no reset; there is no clearing pass after reset.
module multilevel_queue_scheduler #(
    parameter int QUEUE_DEPTH = mlqs_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int TIME_BITS   = mlqs_pkg::DEFAULT_TIME_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mlqs_pkg::req_in_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mlqs_pkg::result_t   m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import mlqs_pkg::*;

    logic [BURST_W-1:0] time_slice_reg;
    logic               req_valid;
    sched_req_t         req;
    logic               req_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIME_SLICE) ? {16'b0, time_slice_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_slice_reg <= TIME_SLICE_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_TIME_SLICE)) begin
            time_slice_reg <= pwdata[BURST_W-1:0];
        end
    end

    mlqs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .req_valid (req_valid),
        .req       (req),
        .req_pop   (req_pop)
    );

    mlqs_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .time_slice (time_slice_reg),
        .req_valid  (req_valid),
        .req        (req),
        .req_pop    (req_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

`ifndef ASSERT_OFF
    a_reject_no_slice: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.rejected |-> !m_data.slice_valid && !m_data.all_done
            || m_valid && m_data.rejected && !m_data.slice_valid)
        else $error("rejected request carries a slice");

    a_idle_result_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.slice_valid |-> (m_data.slice_pid == '0) && !m_data.completed)
        else $error("result without slice has pid or completion");

    a_slice_pid_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.slice_valid |-> (m_data.slice_pid != '0) && !m_data.rejected)
        else $error("dispatched slice has no process number");

    a_pop_needs_request: assert property (@(posedge aclk) disable iff (!aresetn)
        req_pop |-> req_valid)
        else $error("back end took a request from an empty queue");
`endif

endmodule

// ===== bench/mlqs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_checker
// Watches the request, result and register ports of the multilevel queue
// scheduler. Keeps its own model of both queues, the clock of the scheduler,
// the sums and the quantum. Works out the result of every accepted request
// and compares each returned result, field by field, in order.
// ----------------------------------------------------------------------------
module mlqs_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  mlqs_pkg::req_in_t   s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  mlqs_pkg::result_t   m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic [31:0]         prdata,
    input  logic                pready,
    output int unsigned         fail_count,
    output int unsigned         open_count
);
    import mlqs_pkg::*;

    localparam int         QDEPTH          = DEFAULT_QUEUE_DEPTH;
    localparam logic [2:0] TIME_SLICE_ADDR = {REG_TIME_SLICE, 2'b00};

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [BURST_W-1:0] left;
        logic [BURST_W-1:0] burst;
    } rr_job_t;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [BURST_W-1:0] burst;
    } fcfs_job_t;

    rr_job_t            rr_jobs[$];
    fcfs_job_t          fcfs_jobs[$];
    result_t            due_results[$];
    logic [OTIME_W-1:0] sched_clock;
    logic [SUM_W-1:0]   lag_total;
    logic [SUM_W-1:0]   finish_total;
    logic [PID_W-1:0]   pid_last;
    logic [BURST_W-1:0] quantum_cfg;
    int unsigned        mismatches = 0;
    int unsigned        result_no  = 0;

    assign fail_count = mismatches;

    task automatic log_failure(input string msg);
        $display("[%0t] mlqs_checker: result %0d: %s", $realtime, result_no, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            log_failure($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    function automatic logic [OTIME_W-1:0] advance(input logic [OTIME_W-1:0] t,
                                                  input logic [BURST_W-1:0] d);
        logic [OTIME_W:0] s;
        s = {1'b0, t} + {{(OTIME_W-BURST_W+1){1'b0}}, d};
        return s[OTIME_W] ? '1 : s[OTIME_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] accumulate(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic void close_process(input logic [OTIME_W-1:0] fin,
                                          input logic [BURST_W-1:0] burst);
        logic [OTIME_W-1:0] lag;
        lag = (fin >= OTIME_W'(burst)) ? fin - OTIME_W'(burst) : '0;
        lag_total    = accumulate(lag_total, SUM_W'(lag));
        finish_total = accumulate(finish_total, SUM_W'(fin));
    endfunction

    function automatic result_t run_scheduler(input req_in_t r);
        result_t            res;
        rr_job_t            rj;
        fcfs_job_t          fj;
        logic [BURST_W-1:0] quantum;
        logic               full;
        res = '0;
        if (r.req_type == REQ_ENQUEUE) begin
            full = (r.queue_class == CLASS_RR) ? (rr_jobs.size() >= QDEPTH)
                                               : (fcfs_jobs.size() >= QDEPTH);
            if (full || pid_last == '1) begin
                res.rejected = 1'b1;
            end else begin
                pid_last = pid_last + 1'b1;
                if (r.queue_class == CLASS_RR) begin
                    rj.pid   = pid_last;
                    rj.left  = r.burst;
                    rj.burst = r.burst;
                    rr_jobs.push_back(rj);
                end else begin
                    fj.pid   = pid_last;
                    fj.burst = r.burst;
                    fcfs_jobs.push_back(fj);
                end
            end
        end else if (rr_jobs.size() > 0) begin
            rj      = rr_jobs.pop_front();
            quantum = (quantum_cfg == '0) ? BURST_W'(1) : quantum_cfg;
            res.slice_valid = 1'b1;
            res.slice_pid   = rj.pid;
            res.start_time  = sched_clock;
            if (rj.left <= quantum) begin
                sched_clock   = advance(sched_clock, rj.left);
                res.completed = 1'b1;
                close_process(sched_clock, rj.burst);
            end else begin
                sched_clock = advance(sched_clock, quantum);
                rj.left     = rj.left - quantum;
                rr_jobs.push_back(rj);
            end
            res.finish_time = sched_clock;
        end else if (fcfs_jobs.size() > 0) begin
            fj = fcfs_jobs.pop_front();
            res.slice_valid = 1'b1;
            res.slice_pid   = fj.pid;
            res.start_time  = sched_clock;
            sched_clock     = advance(sched_clock, fj.burst);
            res.finish_time = sched_clock;
            res.completed   = 1'b1;
            close_process(sched_clock, fj.burst);
        end
        res.all_done      = (rr_jobs.size() == 0) && (fcfs_jobs.size() == 0);
        res.wait_sum      = lag_total;
        res.finish_sum    = finish_total;
        res.process_count = pid_last;
        return res;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            rr_jobs.delete();
            fcfs_jobs.delete();
            due_results.delete();
            sched_clock  = '0;
            lag_total    = '0;
            finish_total = '0;
            pid_last     = '0;
            quantum_cfg  = TIME_SLICE_RESET;
            open_count  <= 0;
        end else begin
            if (psel === 1'b1 && penable === 1'b1 && pready === 1'b1 &&
                paddr == TIME_SLICE_ADDR) begin
                if (pwrite)
                    quantum_cfg = pwdata[BURST_W-1:0];
                else
                    check_field("time_slice readback", prdata[BURST_W-1:0], quantum_cfg);
            end
            // results first: a request taken on this edge cannot own one yet
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                if (due_results.size() == 0) begin
                    log_failure("result with no request outstanding");
                end else begin
                    want = due_results.pop_front();
                    check_field("slice_valid", m_data.slice_valid, want.slice_valid);
                    check_field("slice_pid", m_data.slice_pid, want.slice_pid);
                    check_field("start_time", m_data.start_time, want.start_time);
                    check_field("finish_time", m_data.finish_time, want.finish_time);
                    check_field("completed", m_data.completed, want.completed);
                    check_field("all_done", m_data.all_done, want.all_done);
                    check_field("rejected", m_data.rejected, want.rejected);
                    check_field("wait_sum", m_data.wait_sum, want.wait_sum);
                    check_field("finish_sum", m_data.finish_sum, want.finish_sum);
                    check_field("process_count", m_data.process_count,
                                want.process_count);
                end
                result_no++;
            end
            if (s_valid === 1'b1 && s_ready === 1'b1)
                due_results.push_back(run_scheduler(s_data));
            open_count <= due_results.size();
        end
    end

endmodule

// ===== bench/tb_multilevel_queue_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multilevel_queue_scheduler
// Drives the scheduler with directed and random enqueue and dispatch
// requests under several quanta, with bursty sending and a stalling
// receiver, and fills both queues past capacity. Checking is done by
// mlqs_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_multilevel_queue_scheduler;
    import mlqs_pkg::*;

    localparam logic [2:0]  TIME_SLICE_ADDR = {REG_TIME_SLICE, 2'b00};
    localparam int unsigned CYCLE_LIMIT     = 200_000;
    localparam int          RANDOM_PHASE    = 10;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_CHOPPY,
        RX_SPARSE
    } rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    req_in_t     s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    result_t     m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int unsigned fail_count;
    int unsigned open_count;
    int unsigned cycle_count = 0;
    rx_mode_t    rx_mode     = RX_OPEN;
    int          rx_run      = 0;
    bit          sender_calm = 1'b1;
    int          burst_left  = 0;

    multilevel_queue_scheduler u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mlqs_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[multilevel_queue_scheduler] ERROR");
            $finish;
        end
    end

    // receiver: ready held for runs of random length
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_run  <= 0;
        end else if (rx_run != 0) begin
            rx_run <= rx_run - 1;
        end else begin
            case (rx_mode)
                RX_OPEN: begin
                    m_ready <= 1'b1;
                end
                RX_CHOPPY: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                    rx_run  <= $urandom_range(0, 5);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                    rx_run  <= $urandom_range(0, 3);
                end
            endcase
        end
    end

    task automatic push_req(input req_in_t r);
        int gap;
        if (!sender_calm && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        if (burst_left != 0)
            burst_left--;
    endtask

    task automatic enqueue(input logic cls, input logic [BURST_W-1:0] len);
        req_in_t r;
        r.req_type    = REQ_ENQUEUE;
        r.burst       = len;
        r.queue_class = cls;
        push_req(r);
    endtask

    task automatic dispatch();
        req_in_t r;
        r.req_type    = REQ_DISPATCH;
        r.burst       = BURST_W'($urandom);
        r.queue_class = 1'($urandom);
        push_req(r);
    endtask

    // stop sending and wait until every result is back
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (open_count != 0);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TIME_SLICE_ADDR;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_quantum(input logic [BURST_W-1:0] q);
        apb_access(1'b1, {16'($urandom), q});
        apb_access(1'b0, '0);
    endtask

    function automatic logic [BURST_W-1:0] pick_burst();
        case ($urandom_range(0, 15))
            0:       return BURST_W'($urandom);
            1:       return '1;
            2:       return '0;
            3:       return BURST_W'($urandom_range(1, 2000));
            default: return BURST_W'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic random_phase(input logic [BURST_W-1:0] q);
        int dispatch_pct;
        settle();
        set_quantum(q);
        sender_calm = ($urandom_range(0, 3) == 0);
        rx_mode <= rx_mode_t'($urandom_range(0, 2));
        dispatch_pct = 30 + 20 * $urandom_range(0, 2);
        repeat (RANDOM_PHASE) begin
            if ($urandom_range(0, 99) < dispatch_pct)
                dispatch();
            else
                enqueue(1'($urandom), pick_burst());
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // quantum out of reset, empty dispatch, slice boundaries, zero burst
        apb_access(1'b0, '0);
        dispatch();
        enqueue(CLASS_RR, 16'd4);
        enqueue(CLASS_RR, 16'd5);
        enqueue(CLASS_RR, 16'd1);
        enqueue(CLASS_FCFS, 16'd0);
        enqueue(CLASS_FCFS, 16'hFFFF);
        enqueue(CLASS_FCFS, 16'd1);
        enqueue(CLASS_RR, 16'd0);
        repeat (9) dispatch();

        // zero quantum acts as one
        settle();
        set_quantum(16'd0);
        enqueue(CLASS_RR, 16'd3);
        enqueue(CLASS_FCFS, 16'd2);
        repeat (5) dispatch();

        // widest quantum
        settle();
        set_quantum(16'hFFFF);
        enqueue(CLASS_RR, 16'hFFFF);
        repeat (2) dispatch();

        // both queues past capacity, then drained
        settle();
        set_quantum(16'd8);
        sender_calm = 1'b0;
        rx_mode <= RX_CHOPPY;
        repeat (DEFAULT_QUEUE_DEPTH + 2) enqueue(CLASS_RR, BURST_W'($urandom_range(1, 8)));
        repeat (DEFAULT_QUEUE_DEPTH + 2) enqueue(CLASS_FCFS, pick_burst());
        repeat (2 * DEFAULT_QUEUE_DEPTH + 8) dispatch();

        random_phase(16'd1);
        random_phase(BURST_W'($urandom_range(2, 40)));
        random_phase(16'hFFFF);
        random_phase(16'd0);
        random_phase(BURST_W'($urandom_range(1, 16'hFFFF)));
        random_phase(16'd4);

        // last mixed round with an open receiver
        settle();
        set_quantum(16'hFFFF);
        sender_calm = 1'b1;
        rx_mode <= RX_OPEN;
        enqueue(CLASS_RR, 16'd5);
        enqueue(CLASS_FCFS, 16'd5);
        repeat (3) dispatch();

        settle();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0)
            $display("[multilevel_queue_scheduler] OK");
        else
            $display("[multilevel_queue_scheduler] ERROR");
        $finish;
    end

endmodule
